@@ src/frr_pkg.sv @@
package frr_pkg;

   localparam int DIV_NW = 64;
   localparam int DIV_DW = 48;
   localparam int SQ_IW  = 64;
   localparam int SQ_OW  = SQ_IW / 2;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [63:0] ONE_Q28 = 64'd1 << 28;

   typedef logic signed [15:0] q14_type;

   typedef struct packed {
      q14_type [2:0] wo;
      q14_type [2:0] nv;
      q14_type [2:0] rf;
      logic          flip;
      logic [15:0]   n;
      logic [17:0]   ci;
   } fb_type;

   typedef struct packed {
      fb_type             f;
      logic [15:0]        neff;
      logic               omneg;
      logic               refr;
      logic [2:0]         neg;
      logic               mzero;
      logic [2:0][29:0]   nm;
      logic [47:0]        kabs;
      logic [47:0]        bb;
      logic [43:0]        cc;
      logic [43:0]        dd;
   } ctx_type;

   typedef struct packed {
      q14_type [2:0] reflect;
      q14_type [2:0] refract;
      logic          refract_valid;
      q14_type [2:0] facing;
      logic [15:0]   factor;
   } res_type;

endpackage

@@ src/frr_div.sv @@
module frr_div import frr_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [DIV_NW-1:0] num,
   input  logic [DIV_DW-1:0] den,
   output logic [DIV_NW-1:0] quo
);

   logic [DIV_DW-1:0] rem_ff [DIV_NW];
   logic [DIV_NW-1:0] nq_ff  [DIV_NW];
   logic [DIV_DW-1:0] den_ff [DIV_NW];

   for (genvar j = 0; j < DIV_NW; j++) begin : g_stage
      logic [DIV_DW-1:0] rem_prev;
      logic [DIV_NW-1:0] nq_prev;
      logic [DIV_DW-1:0] den_prev;
      logic [DIV_DW:0]   trial;
      logic              ge;
      logic [DIV_DW-1:0] rem_in;
      logic [DIV_NW-1:0] nq_in;

      if (j == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = num;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign nq_prev  = nq_ff[j-1];
         assign den_prev = den_ff[j-1];
      end

      always_comb begin
         trial  = {rem_prev, nq_prev[DIV_NW-1]};
         ge     = trial >= {1'b0, den_prev};
         rem_in = ge ? DIV_DW'(trial - {1'b0, den_prev}) : trial[DIV_DW-1:0];
         nq_in  = {nq_prev[DIV_NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            nq_ff[j]  <= nq_in;
            den_ff[j] <= den_prev;
         end
      end
   end

   assign quo = nq_ff[DIV_NW-1];

endmodule

@@ src/frr_sqrt.sv @@
module frr_sqrt import frr_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [SQ_IW-1:0] rad,
   output logic [SQ_OW-1:0] root
);

   logic [SQ_OW+1:0] rem_ff  [SQ_OW];
   logic [SQ_OW-1:0] root_ff [SQ_OW];
   logic [SQ_IW-1:0] v_ff    [SQ_OW];

   for (genvar j = 0; j < SQ_OW; j++) begin : g_stage
      logic [SQ_OW+1:0] rem_prev;
      logic [SQ_OW-1:0] root_prev;
      logic [SQ_IW-1:0] v_prev;
      logic [SQ_OW+3:0] acc;
      logic [SQ_OW+3:0] trial;
      logic             ge;
      logic [SQ_OW+1:0] rem_in;
      logic [SQ_OW-1:0] root_in;

      if (j == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign v_prev    = rad;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign v_prev    = v_ff[j-1];
      end

      always_comb begin
         acc     = {rem_prev, v_prev[SQ_IW-1:SQ_IW-2]};
         trial   = {2'b00, root_prev, 2'b01};
         ge      = acc >= trial;
         rem_in  = ge ? (SQ_OW+2)'(acc - trial) : acc[SQ_OW+1:0];
         root_in = {root_prev[SQ_OW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            v_ff[j]    <= {v_prev[SQ_IW-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[SQ_OW-1];

endmodule

@@ src/frr_fifo.sv @@
module frr_fifo import frr_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  fb_type wdata,
   output logic   full,
   input  logic   pop,
   output fb_type rdata,
   output logic   empty
);

   fb_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wp_ff, wp_in;
   logic [FIFO_AW-1:0]   rp_ff, rp_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full    = cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

endmodule

@@ src/frr_front.sv @@
module frr_front import frr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  q14_type       req_out_dir_x,
   input  q14_type       req_out_dir_y,
   input  q14_type       req_out_dir_z,
   input  q14_type       req_normal_x,
   input  q14_type       req_normal_y,
   input  q14_type       req_normal_z,
   input  logic [15:0]   req_index_ratio,
   output logic          q_push,
   output fb_type        q_data,
   input  logic          q_full
);

   logic adv;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   q14_type [2:0]        wo1_ff, nv1_ff, wo2_ff, nv2_ff, wo3_ff, nv3_ff, wo4_ff, nv4_ff;
   logic [15:0]          n1_ff, n2_ff, n3_ff, n4_ff;
   logic signed [31:0]   p2_ff [3];
   logic signed [31:0]   p2_in [3];
   logic                 flip3_ff, flip4_ff;
   logic [31:0]          dabs3_ff;
   logic [17:0]          ci3_ff, ci4_ff;
   logic signed [48:0]   r4_ff [3];
   logic signed [48:0]   r4_in [3];
   fb_type               d5_ff, d5_in;

   logic signed [33:0]   dot;
   logic                 flip3_in;
   logic [31:0]          dabs3_in;
   logic [17:0]          ci3_in;
   q14_type [2:0]        nv3_in;

   assign adv      = !v5_ff || !q_full;
   assign req_full = !adv;
   assign q_push   = v5_ff;
   assign q_data   = d5_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p2_in[i] = 32'(wo1_ff[i]) * 32'(nv1_ff[i]);
      end
      dot      = 34'(p2_ff[0]) + 34'(p2_ff[1]) + 34'(p2_ff[2]);
      flip3_in = dot[33];
      dabs3_in = flip3_in ? 32'(-dot) : dot[31:0];
      ci3_in   = 18'((33'(dabs3_in) + 33'd8192) >> 14);
      for (int i = 0; i < 3; i++) begin
         if (!flip3_in) begin
            nv3_in[i] = nv2_ff[i];
         end else if (nv2_ff[i] == -16'sd32768) begin
            nv3_in[i] = 16'sd32767;
         end else begin
            nv3_in[i] = -nv2_ff[i];
         end
      end
   end

   always_comb begin
      logic [47:0]        mag;
      logic [21:0]        r;
      logic signed [23:0] sr;
      logic signed [23:0] diff;
      for (int i = 0; i < 3; i++) begin
         r4_in[i] = 49'($signed({1'b0, dabs3_ff})) * 49'(nv3_ff[i]);
      end
      d5_in      = '0;
      d5_in.wo   = wo4_ff;
      d5_in.nv   = nv4_ff;
      d5_in.flip = flip4_ff;
      d5_in.n    = n4_ff;
      d5_in.ci   = ci4_ff;
      for (int i = 0; i < 3; i++) begin
         mag  = r4_ff[i][48] ? 48'(-r4_ff[i]) : r4_ff[i][47:0];
         r    = 22'((49'(mag) + 49'd67108864) >> 27);
         sr   = r4_ff[i][48] ? -$signed({2'b00, r}) : $signed({2'b00, r});
         diff = sr - 24'(wo4_ff[i]);
         if (diff > 24'sd32767) begin
            d5_in.rf[i] = 16'sd32767;
         end else if (diff < -24'sd32768) begin
            d5_in.rf[i] = -16'sd32768;
         end else begin
            d5_in.rf[i] = diff[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_push;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wo1_ff   <= {req_out_dir_z, req_out_dir_y, req_out_dir_x};
         nv1_ff   <= {req_normal_z, req_normal_y, req_normal_x};
         n1_ff    <= req_index_ratio;
         wo2_ff   <= wo1_ff;
         nv2_ff   <= nv1_ff;
         n2_ff    <= n1_ff;
         for (int i = 0; i < 3; i++) begin
            p2_ff[i] <= p2_in[i];
            r4_ff[i] <= r4_in[i];
         end
         wo3_ff   <= wo2_ff;
         nv3_ff   <= nv3_in;
         n3_ff    <= n2_ff;
         flip3_ff <= flip3_in;
         dabs3_ff <= dabs3_in;
         ci3_ff   <= ci3_in;
         wo4_ff   <= wo3_ff;
         nv4_ff   <= nv3_ff;
         n4_ff    <= n3_ff;
         flip4_ff <= flip3_ff;
         ci4_ff   <= ci3_ff;
         d5_ff    <= d5_in;
      end
   end

endmodule

@@ src/frr_back.sv @@
module frr_back import frr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  fb_type  q_data,
   input  logic    q_empty,
   output logic    q_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output res_type rsp_data
);

   function automatic logic [5:0] msb64(input logic [63:0] x);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   logic adv;

   // stage valids
   logic v0_ff, va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff, vi_ff;
   logic vj_ff, vk_ff, vl_ff, vm_ff, vn_ff, vo_ff, vp_ff;
   logic [DIV_NW-1:0] l1v_ff, l2v_ff, l5v_ff;
   logic [SQ_OW-1:0]  l3v_ff, l4v_ff;

   ctx_type c0_ff, ca_ff, cb_ff, cc_ff, cd_ff, ce_ff, cf_ff, cg_ff, ch_ff, ci_ff;
   ctx_type cj_ff, ck_ff, cl_ff, cm_ff, cn_ff, co_ff;
   ctx_type c0_in, ca_in, cb_in, cc_in, cg_in, cj_in, ck_in;
   ctx_type ce_in;
   ctx_type l1_ff [DIV_NW];
   ctx_type l2_ff [DIV_NW];
   ctx_type l5_ff [DIV_NW];
   ctx_type l3_ff [SQ_OW];
   ctx_type l4_ff [SQ_OW];

   logic [DIV_NW-1:0] quo1, quo2, quo_s, quo_p;
   logic [DIV_NW-1:0] quo_r [3];
   logic [SQ_OW-1:0]  root1, root2;

   logic [31:0]        nn_a_ff;
   logic [35:0]        cici_a_ff;
   logic [DIV_NW-1:0]  num_b_ff;
   logic [DIV_DW-1:0]  den_b_ff;
   logic [63:0]        c2_c_ff, c2_c_in;
   logic [30:0]        cost_d_ff;
   logic [46:0]        costn_d_ff;
   logic [33:0]        nci_d_ff;
   logic signed [48:0] k_e_ff, k_e_in;
   logic signed [64:0] tp_f_ff [3];
   logic [63:0]        mag_g_ff [3];
   logic [63:0]        mag_h_ff [3];
   logic [63:0]        mag_i_ff [3];
   logic [63:0]        mag_j_ff [3];
   logic [63:0]        m01_h_ff, mx_i_ff;
   logic [5:0]         p_j_ff;
   logic [59:0]        sq_l_ff [3];
   logic [63:0]        len2_m_ff;
   logic [DIV_NW-1:0]  rnum_n_ff [3];
   logic [DIV_DW-1:0]  len_n_ff;
   logic [DIV_NW-1:0]  snum_n_ff, pnum_n_ff;
   logic [DIV_DW-1:0]  sden_n_ff, pden_n_ff;
   q14_type [2:0]      rfr_o_ff, rfr_o_in;
   logic [33:0]        rs2_o_ff, rp2_o_ff;
   res_type            res_p_ff, res_p_in;

   logic [63:0]        mag_g_in [3];
   logic [29:0]        nm_k [3];

   assign adv       = !vp_ff || rsp_pop;
   assign q_pop     = adv && !q_empty;
   assign rsp_empty = !vp_ff;
   assign rsp_data  = res_p_ff;

   frr_div u_div_inv (
      .clock(clock), .en(adv),
      .num(DIV_NW'(25'h1000000 + 25'(c0_ff.f.n >> 1))),
      .den(DIV_DW'(c0_ff.f.n)),
      .quo(quo1)
   );

   frr_div u_div_q (
      .clock(clock), .en(adv), .num(num_b_ff), .den(den_b_ff), .quo(quo2)
   );

   frr_sqrt u_sqrt_cos (
      .clock(clock), .en(adv), .rad(c2_c_ff), .root(root1)
   );

   frr_sqrt u_sqrt_len (
      .clock(clock), .en(adv), .rad(len2_m_ff), .root(root2)
   );

   for (genvar i = 0; i < 3; i++) begin : g_rdiv
      frr_div u_div_rf (
         .clock(clock), .en(adv), .num(rnum_n_ff[i]), .den(len_n_ff), .quo(quo_r[i])
      );
   end

   frr_div u_div_rs (
      .clock(clock), .en(adv), .num(snum_n_ff), .den(sden_n_ff), .quo(quo_s)
   );

   frr_div u_div_rp (
      .clock(clock), .en(adv), .num(pnum_n_ff), .den(pden_n_ff), .quo(quo_p)
   );

   always_comb begin
      logic [15:0]        neff;
      logic               omneg;
      logic               refr;
      logic [63:0]        c2;
      logic [29:0]        ci4096;
      logic [42:0]        cost4096;
      logic signed [44:0] cdiff;
      logic signed [64:0] t;
      logic [5:0]         p;

      c0_in   = '0;
      c0_in.f = q_data;

      // flip the index when the normal was flipped
      ca_in = l1_ff[DIV_NW-1];
      if (ca_in.f.flip && ca_in.f.n != '0) begin
         neff = (quo1[DIV_NW-1:16] != '0) ? 16'hFFFF : quo1[15:0];
      end else begin
         neff = ca_in.f.n;
      end
      ca_in.neff = neff;

      cb_in       = ca_ff;
      omneg       = cici_a_ff > 36'(ONE_Q28);
      cb_in.omneg = omneg;

      cc_in = l2_ff[DIV_NW-1];
      refr  = cc_in.neff != '0 && (cc_in.omneg || quo2 < ONE_Q28);
      c2    = cc_in.omneg ? ONE_Q28 + quo2 : ONE_Q28 - quo2;
      cc_in.refr = refr;
      c2_c_in    = refr ? c2 : '0;

      ce_in    = cd_ff;
      ci4096   = {cd_ff.f.ci, 12'b0};
      cost4096 = {cost_d_ff, 12'b0};
      k_e_in   = $signed({19'b0, ci4096}) - $signed({2'b0, costn_d_ff});
      ce_in.kabs = k_e_in[48] ? 48'(-k_e_in) : k_e_in[47:0];
      ce_in.bb   = 48'(ci4096) + 48'(costn_d_ff);
      cdiff      = $signed({2'b0, cost4096}) - $signed({11'b0, nci_d_ff});
      ce_in.cc   = cdiff[44] ? 44'(-cdiff) : cdiff[43:0];
      ce_in.dd   = 44'(cost4096) + 44'(nci_d_ff);

      cg_in = cf_ff;
      for (int i = 0; i < 3; i++) begin
         t = tp_f_ff[i] - (65'(cf_ff.f.wo[i]) <<< 26);
         cg_in.neg[i] = t[64];
         mag_g_in[i]  = t[64] ? 64'(-t) : t[63:0];
      end

      cj_in       = ci_ff;
      cj_in.mzero = mx_i_ff == '0;

      ck_in = cj_ff;
      p     = p_j_ff;
      for (int i = 0; i < 3; i++) begin
         if (p >= 6'd29) begin
            nm_k[i] = 30'(mag_j_ff[i] >> (p - 6'd29));
         end else begin
            nm_k[i] = 30'(mag_j_ff[i] << (6'd29 - p));
         end
         ck_in.nm[i] = nm_k[i];
      end

      for (int i = 0; i < 3; i++) begin
         rfr_o_in[i] = '0;
         if (!l5_ff[DIV_NW-1].mzero) begin
            if (!l5_ff[DIV_NW-1].neg[i]) begin
               rfr_o_in[i] = (quo_r[i][DIV_NW-1:15] != '0) ? 16'h7FFF : quo_r[i][15:0];
            end else if (quo_r[i][DIV_NW-1:16] != '0 || quo_r[i][15:0] > 16'h8000) begin
               rfr_o_in[i] = 16'h8000;
            end else begin
               rfr_o_in[i] = 16'(~quo_r[i][15:0] + 16'd1);
            end
         end
      end
   end

   always_comb begin
      logic [34:0] fsum;
      logic [18:0] f;
      res_p_in.reflect = co_ff.f.rf;
      res_p_in.facing  = co_ff.f.nv;
      fsum = 35'(rs2_o_ff) + 35'(rp2_o_ff) + 35'd32768;
      f    = 19'(fsum >> 16);
      if (co_ff.refr) begin
         res_p_in.refract       = rfr_o_ff;
         res_p_in.refract_valid = 1'b1;
         res_p_in.factor        = (f > 19'd32768) ? 16'd32768 : f[15:0];
      end else begin
         res_p_in.refract       = '0;
         res_p_in.refract_valid = 1'b0;
         res_p_in.factor        = 16'd32768;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         l1v_ff <= '0;
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
         l2v_ff <= '0;
         vc_ff  <= 1'b0;
         l3v_ff <= '0;
         vd_ff  <= 1'b0;
         ve_ff  <= 1'b0;
         vf_ff  <= 1'b0;
         vg_ff  <= 1'b0;
         vh_ff  <= 1'b0;
         vi_ff  <= 1'b0;
         vj_ff  <= 1'b0;
         vk_ff  <= 1'b0;
         vl_ff  <= 1'b0;
         vm_ff  <= 1'b0;
         l4v_ff <= '0;
         vn_ff  <= 1'b0;
         l5v_ff <= '0;
         vo_ff  <= 1'b0;
         vp_ff  <= 1'b0;
      end else if (adv) begin
         v0_ff  <= !q_empty;
         l1v_ff <= {l1v_ff[DIV_NW-2:0], v0_ff};
         va_ff  <= l1v_ff[DIV_NW-1];
         vb_ff  <= va_ff;
         l2v_ff <= {l2v_ff[DIV_NW-2:0], vb_ff};
         vc_ff  <= l2v_ff[DIV_NW-1];
         l3v_ff <= {l3v_ff[SQ_OW-2:0], vc_ff};
         vd_ff  <= l3v_ff[SQ_OW-1];
         ve_ff  <= vd_ff;
         vf_ff  <= ve_ff;
         vg_ff  <= vf_ff;
         vh_ff  <= vg_ff;
         vi_ff  <= vh_ff;
         vj_ff  <= vi_ff;
         vk_ff  <= vj_ff;
         vl_ff  <= vk_ff;
         vm_ff  <= vl_ff;
         l4v_ff <= {l4v_ff[SQ_OW-2:0], vm_ff};
         vn_ff  <= l4v_ff[SQ_OW-1];
         l5v_ff <= {l5v_ff[DIV_NW-2:0], vn_ff};
         vo_ff  <= l5v_ff[DIV_NW-1];
         vp_ff  <= vo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c0_ff <= c0_in;

         l1_ff[0] <= c0_ff;
         l2_ff[0] <= cb_ff;
         l3_ff[0] <= cc_ff;
         l4_ff[0] <= cm_ff;
         l5_ff[0] <= cn_ff;
         for (int i = 1; i < DIV_NW; i++) begin
            l1_ff[i] <= l1_ff[i-1];
            l2_ff[i] <= l2_ff[i-1];
            l5_ff[i] <= l5_ff[i-1];
         end
         for (int i = 1; i < SQ_OW; i++) begin
            l3_ff[i] <= l3_ff[i-1];
            l4_ff[i] <= l4_ff[i-1];
         end

         ca_ff     <= ca_in;
         nn_a_ff   <= 32'(ca_in.neff) * 32'(ca_in.neff);
         cici_a_ff <= 36'(ca_in.f.ci) * 36'(ca_in.f.ci);

         cb_ff    <= cb_in;
         num_b_ff <= DIV_NW'({cb_in.omneg ? cici_a_ff - 36'(ONE_Q28)
                                          : 36'(ONE_Q28) - cici_a_ff, 24'b0});
         den_b_ff <= DIV_DW'(nn_a_ff);

         cc_ff   <= cc_in;
         c2_c_ff <= c2_c_in;

         cd_ff      <= l3_ff[SQ_OW-1];
         cost_d_ff  <= root1[30:0];
         costn_d_ff <= 47'(root1[30:0]) * 47'(l3_ff[SQ_OW-1].neff);
         nci_d_ff   <= 34'(l3_ff[SQ_OW-1].neff) * 34'(l3_ff[SQ_OW-1].f.ci);

         ce_ff  <= ce_in;
         k_e_ff <= k_e_in;

         cf_ff <= ce_ff;
         for (int i = 0; i < 3; i++) begin
            tp_f_ff[i] <= 65'(k_e_ff) * 65'(ce_ff.f.nv[i]);
         end

         cg_ff <= cg_in;
         for (int i = 0; i < 3; i++) begin
            mag_g_ff[i] <= mag_g_in[i];
            mag_h_ff[i] <= mag_g_ff[i];
            mag_i_ff[i] <= mag_h_ff[i];
            mag_j_ff[i] <= mag_i_ff[i];
         end

         ch_ff    <= cg_ff;
         m01_h_ff <= (mag_g_ff[0] > mag_g_ff[1]) ? mag_g_ff[0] : mag_g_ff[1];

         ci_ff   <= ch_ff;
         mx_i_ff <= (m01_h_ff > mag_h_ff[2]) ? m01_h_ff : mag_h_ff[2];

         cj_ff  <= cj_in;
         p_j_ff <= msb64(mx_i_ff);

         ck_ff <= ck_in;

         cl_ff <= ck_ff;
         for (int i = 0; i < 3; i++) begin
            sq_l_ff[i] <= 60'(ck_ff.nm[i]) * 60'(ck_ff.nm[i]);
         end

         cm_ff     <= cl_ff;
         len2_m_ff <= 64'(sq_l_ff[0]) + 64'(sq_l_ff[1]) + 64'(sq_l_ff[2]);

         cn_ff    <= l4_ff[SQ_OW-1];
         len_n_ff <= DIV_DW'(root2);
         for (int i = 0; i < 3; i++) begin
            rnum_n_ff[i] <= DIV_NW'({l4_ff[SQ_OW-1].nm[i], 14'b0}) + DIV_NW'(root2 >> 1);
         end
         snum_n_ff <= DIV_NW'({l4_ff[SQ_OW-1].kabs, 15'b0})
                      + DIV_NW'(l4_ff[SQ_OW-1].bb >> 1);
         sden_n_ff <= DIV_DW'(l4_ff[SQ_OW-1].bb);
         pnum_n_ff <= DIV_NW'({l4_ff[SQ_OW-1].cc, 15'b0})
                      + DIV_NW'(l4_ff[SQ_OW-1].dd >> 1);
         pden_n_ff <= DIV_DW'(l4_ff[SQ_OW-1].dd);

         co_ff    <= l5_ff[DIV_NW-1];
         rfr_o_ff <= rfr_o_in;
         rs2_o_ff <= 34'(quo_s[16:0]) * 34'(quo_s[16:0]);
         rp2_o_ff <= 34'(quo_p[16:0]) * 34'(quo_p[16:0]);

         res_p_ff <= res_p_in;
      end
   end

endmodule

@@ src/fresnel_reflect_refract.sv @@
// channel   | direction | handshake              | payload
// req_*     | in        | req_push / req_full    | outgoing direction, normal, index ratio
// rsp_*     | out       | rsp_pop / rsp_empty    | reflect, refract, facing normal, factor
//
// One item per cycle sustained while results are popped as they appear.
// The back end chains five units: three levels of 64-step
// dividers and two 32-step square roots, each one bit or digit a stage.
// Reset clears all valid bits and queue pointers; no data is cleared.
// A held result stalls the back end; the front end keeps taking items
// until the four-entry queue between them fills.
module fresnel_reflect_refract import frr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  q14_type     req_out_dir_x,
   input  q14_type     req_out_dir_y,
   input  q14_type     req_out_dir_z,
   input  q14_type     req_normal_x,
   input  q14_type     req_normal_y,
   input  q14_type     req_normal_z,
   input  logic [15:0] req_index_ratio,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output q14_type     rsp_reflect_x,
   output q14_type     rsp_reflect_y,
   output q14_type     rsp_reflect_z,
   output q14_type     rsp_refract_x,
   output q14_type     rsp_refract_y,
   output q14_type     rsp_refract_z,
   output logic        rsp_refract_valid,
   output q14_type     rsp_facing_normal_x,
   output q14_type     rsp_facing_normal_y,
   output q14_type     rsp_facing_normal_z,
   output logic [15:0] rsp_fresnel_factor
);

   logic    fq_push, fq_full, fq_pop, fq_empty;
   fb_type  fq_wdata, fq_rdata;
   res_type res;

   frr_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_out_dir_x(req_out_dir_x), .req_out_dir_y(req_out_dir_y),
      .req_out_dir_z(req_out_dir_z),
      .req_normal_x(req_normal_x), .req_normal_y(req_normal_y),
      .req_normal_z(req_normal_z),
      .req_index_ratio(req_index_ratio),
      .q_push(fq_push), .q_data(fq_wdata), .q_full(fq_full)
   );

   frr_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(fq_push), .wdata(fq_wdata), .full(fq_full),
      .pop(fq_pop), .rdata(fq_rdata), .empty(fq_empty)
   );

   frr_back u_back (
      .clock(clock), .reset(reset),
      .q_data(fq_rdata), .q_empty(fq_empty), .q_pop(fq_pop),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(res)
   );

   assign rsp_reflect_x       = res.reflect[0];
   assign rsp_reflect_y       = res.reflect[1];
   assign rsp_reflect_z       = res.reflect[2];
   assign rsp_refract_x       = res.refract[0];
   assign rsp_refract_y       = res.refract[1];
   assign rsp_refract_z       = res.refract[2];
   assign rsp_refract_valid   = res.refract_valid;
   assign rsp_facing_normal_x = res.facing[0];
   assign rsp_facing_normal_y = res.facing[1];
   assign rsp_facing_normal_z = res.facing[2];
   assign rsp_fresnel_factor  = res.factor;

endmodule
